/* hdl/tick_delay_task_scheduler_unit_assert.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef TICK_DELAY_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define TICK_DELAY_TASK_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TDTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdts: assertion failed");

// next-cycle implication
`define TDTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdts: assertion failed");

`endif

/* hdl/tdts_pkg.sv */
// Types and constants of the tick delay task scheduler.
package tdts_pkg;

  localparam int ID_W           = 4;
  localparam int DELAY_W        = 32;
  localparam int MAX_TASKS      = 1 << ID_W;
  localparam int TASK_COUNT_DEF = 16;
  localparam int IN_DATA_W      = 40;
  localparam int OUT_DATA_W     = 40;

  typedef enum logic [2:0] {
    K_CREATE = 3'd0,
    K_STOP   = 3'd1,
    K_READY  = 3'd2,
    K_SLEEP  = 3'd3,
    K_TICK   = 3'd4,
    K_SCHED  = 3'd5,
    K_QUERY  = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    TS_READY = 2'd0,
    TS_WAIT  = 2'd1,
    TS_STOP  = 2'd2,
    TS_NONE  = 2'd3
  } task_state_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_QUERY,
    S_WALK,
    S_FLUSH
  } fsm_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic               expired;
  } dly_res_t;

endpackage

/* hdl/tdts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tdts_ram #(
  parameter  int WIDTH  = 32,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/tdts_delay_unit.sv */
// Shared delay unit: lowers a task delay by the pass ticks, floored at zero.
module tdts_delay_unit (
  input  logic [tdts_pkg::DELAY_W-1:0] delay,
  input  logic [tdts_pkg::DELAY_W-1:0] ticks,
  output tdts_pkg::dly_res_t           res
);
  import tdts_pkg::*;

  logic expired;

  assign expired     = (delay <= ticks);
  assign res.expired = expired;
  assign res.delay   = expired ? '0 : (delay - ticks);

endmodule

/* hdl/tick_delay_task_scheduler_unit.sv */
// Tick delay task scheduler: task table, pending tick count and schedule walker.
//
// The block holds min(TASK_COUNT,16) tasks. Create, stop, ready, sleep, tick and
// unused kinds are done as they are accepted in the idle state. A query passes
// through the query state, which also waits out any output stall, since the delay
// comes from a memory with a registered read. A schedule pass with pending ticks
// runs the walk state and then the flush state: the walker visits one task per
// cycle through the single delay memory and one shared subtract and compare unit,
// and holds whenever a grant word cannot leave the output register. The input is
// not ready until a query or pass has loaded its last word into the output
// register. A schedule with no pending ticks stays idle and sends nothing.
`include "tick_delay_task_scheduler_unit_assert.svh"

module tick_delay_task_scheduler_unit #(
  parameter int TASK_COUNT = tdts_pkg::TASK_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [3:0] task_id, [35:4] sleep_ticks, [39:36] zero
  input  logic [tdts_pkg::IN_DATA_W-1:0] in_tdata,
  // [2:0] kind
  input  logic [2:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [3:0] task_id_out, [5:4] task_state_out, [37:6] delay_out, [39:38] zero
  output logic [tdts_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] granted
  output logic [0:0]                     out_tuser,
  output logic                           out_tlast
);
  import tdts_pkg::*;

  localparam int DEPTH = (TASK_COUNT < MAX_TASKS) ? TASK_COUNT : MAX_TASKS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  kind_t              in_kind;
  logic [ID_W-1:0]    in_id;
  logic [DELAY_W-1:0] in_ticks;
  logic               id_ok;
  logic [IDX_W-1:0]   id_idx;

  fsm_t               state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [ID_W-1:0]    qid_r, qid_nxt;
  logic               qok_r, qok_nxt;
  logic [DELAY_W-1:0] ticks_r, ticks_nxt;
  logic [DELAY_W-1:0] pending_r, pending_nxt;
  logic [DEPTH-1:0]   created_r, created_nxt;
  task_state_t        tstate_r [DEPTH];
  task_state_t        tstate_nxt [DEPTH];

  logic               hold_vld_r, hold_vld_nxt;
  logic [IDX_W-1:0]   hold_id_r, hold_id_nxt;
  logic [DELAY_W-1:0] hold_dly_r, hold_dly_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic               out_granted_r, out_granted_nxt;
  task_state_t        out_tstate_r, out_tstate_nxt;
  logic [DELAY_W-1:0] out_delay_r, out_delay_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_free;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [DELAY_W-1:0] ram_wdata;
  logic [DELAY_W-1:0] ram_rdata;

  dly_res_t           du_res;
  task_state_t        cur_state;
  task_state_t        new_state;
  logic               cur_created;
  logic               grant;
  logic               step_go;
  logic               tick_go;
  logic               sched_go;

  assign in_kind  = kind_t'(in_tuser);
  assign in_id    = in_tdata[ID_W-1:0];
  assign in_ticks = in_tdata[ID_W +: DELAY_W];
  assign id_ok    = ({1'b0, in_id} < (ID_W + 1)'(DEPTH));
  assign id_idx   = in_id[IDX_W-1:0];

  assign in_tready  = (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_delay_r, out_tstate_r, out_id_r};
  assign out_tuser  = out_granted_r;
  assign out_tlast  = out_last_r;

  tdts_ram #(
    .WIDTH (DELAY_W),
    .DEPTH (DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_nxt),
    .rdata (ram_rdata)
  );

  tdts_delay_unit u_delay_unit (
    .delay (ram_rdata),
    .ticks (ticks_r),
    .res   (du_res)
  );

  // walker view of the task at idx_r; delay word arrives from the memory
  assign cur_created = created_r[idx_r];
  assign cur_state   = tstate_r[idx_r];
  assign new_state   = (du_res.expired && cur_state == TS_WAIT) ? TS_READY : cur_state;
  assign grant       = cur_created && (new_state == TS_READY);
  // a second grant pushes the held one out, so it needs the output register
  assign step_go     = !(grant && hold_vld_r) || out_free;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    qid_nxt         = qid_r;
    qok_nxt         = qok_r;
    ticks_nxt       = ticks_r;
    pending_nxt     = pending_r;
    created_nxt     = created_r;
    tstate_nxt      = tstate_r;
    hold_vld_nxt    = hold_vld_r;
    hold_id_nxt     = hold_id_r;
    hold_dly_nxt    = hold_dly_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_id_nxt      = out_id_r;
    out_granted_nxt = out_granted_r;
    out_tstate_nxt  = out_tstate_r;
    out_delay_nxt   = out_delay_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_waddr       = idx_r;
    ram_wdata       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_kind)
            K_CREATE: begin
              if (id_ok) begin
                created_nxt[id_idx] = 1'b1;
                tstate_nxt[id_idx]  = TS_READY;
                ram_we              = 1'b1;
                ram_waddr           = id_idx;
                ram_wdata           = '0;
              end
            end
            K_STOP: begin
              if (id_ok) begin
                tstate_nxt[id_idx] = TS_STOP;
              end
            end
            K_READY: begin
              if (id_ok) begin
                tstate_nxt[id_idx] = TS_READY;
              end
            end
            K_SLEEP: begin
              if (id_ok) begin
                tstate_nxt[id_idx] = TS_WAIT;
                ram_we             = 1'b1;
                ram_waddr          = id_idx;
                ram_wdata          = in_ticks;
              end
            end
            K_TICK: begin
              if (pending_r != '1) begin
                pending_nxt = pending_r + DELAY_W'(1);
              end
            end
            K_SCHED: begin
              if (pending_r != '0) begin
                ticks_nxt    = pending_r;
                pending_nxt  = '0;
                idx_nxt      = '0;
                hold_vld_nxt = 1'b0;
                state_nxt    = S_WALK;
              end
            end
            K_QUERY: begin
              qid_nxt   = in_id;
              qok_nxt   = id_ok;
              idx_nxt   = id_idx;
              state_nxt = S_QUERY;
            end
            default: begin
            end
          endcase
        end
      end

      S_QUERY: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_id_nxt      = qid_r;
          out_granted_nxt = 1'b0;
          out_last_nxt    = 1'b1;
          if (qok_r && created_r[idx_r]) begin
            out_tstate_nxt = tstate_r[idx_r];
            out_delay_nxt  = ram_rdata;
          end else begin
            out_tstate_nxt = TS_NONE;
            out_delay_nxt  = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      S_WALK: begin
        if (step_go) begin
          if (cur_created) begin
            ram_we            = 1'b1;
            ram_waddr         = idx_r;
            ram_wdata         = du_res.delay;
            tstate_nxt[idx_r] = new_state;
          end
          if (grant) begin
            if (hold_vld_r) begin
              out_valid_nxt   = 1'b1;
              out_id_nxt      = ID_W'(hold_id_r);
              out_granted_nxt = 1'b1;
              out_tstate_nxt  = TS_READY;
              out_delay_nxt   = hold_dly_r;
              out_last_nxt    = 1'b0;
            end
            hold_vld_nxt = 1'b1;
            hold_id_nxt  = idx_r;
            hold_dly_nxt = du_res.delay;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_last_nxt    = 1'b1;
          out_tstate_nxt  = TS_READY;
          out_granted_nxt = hold_vld_r;
          if (hold_vld_r) begin
            out_id_nxt    = ID_W'(hold_id_r);
            out_delay_nxt = hold_dly_r;
          end else begin
            out_id_nxt    = '0;
            out_delay_nxt = '0;
          end
          hold_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pending_r   <= '0;
      created_r   <= '0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      created_r   <= created_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    qid_r         <= qid_nxt;
    qok_r         <= qok_nxt;
    ticks_r       <= ticks_nxt;
    tstate_r      <= tstate_nxt;
    hold_id_r     <= hold_id_nxt;
    hold_dly_r    <= hold_dly_nxt;
    out_id_r      <= out_id_nxt;
    out_granted_r <= out_granted_nxt;
    out_tstate_r  <= out_tstate_nxt;
    out_delay_r   <= out_delay_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign tick_go  = in_tvalid && in_tready && in_kind == K_TICK && pending_r != '1;
  assign sched_go = in_tvalid && in_tready && in_kind == K_SCHED;

  `TDTS_ASSERT_NXT(a_tick_count, tick_go, pending_r == $past(pending_r) + 32'd1)
  `TDTS_ASSERT_NXT(a_sched_takes_ticks, sched_go, pending_r == '0)
  `TDTS_ASSERT_IMP(a_walk_has_ticks, state_r == S_WALK, ticks_r != '0)
  `TDTS_ASSERT_IMP(a_nogrant_is_last, out_valid_r && !out_granted_r, out_last_r)
  `TDTS_ASSERT_IMP(a_grant_is_ready, out_valid_r && out_granted_r, out_tstate_r == TS_READY)

endmodule

/* bench/tick_delay_task_scheduler_unit_test.sv */
// Self-checking bench for the tick delay task scheduler: directed and random event words.
module tick_delay_task_scheduler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tdts_pkg::*;

  localparam int TASKS        = 16;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] K_UNUSED = 3'd7;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic               granted;
    task_state_t        st;
    logic [DELAY_W-1:0] delay;
    logic               last;
  } report_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [2:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tlast;

  // mirror of the block's task table
  logic               task_made [TASKS];
  task_state_t        task_st   [TASKS];
  logic [DELAY_W-1:0] task_dly  [TASKS];
  logic [DELAY_W-1:0] ticks_owed;

  report_t reports_due[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int errors        = 0;
  int words_sent    = 0;
  int reports_seen  = 0;
  int grants_seen   = 0;
  int cycle_count   = 0;

  tick_delay_task_scheduler_unit #(.TASK_COUNT(TASKS)) u_top (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d result words outstanding",
               cycle_count, reports_due.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Apply one accepted event word to the mirror and queue the words it yields.
  task automatic update_task_table(logic [2:0] kind, logic [ID_W-1:0] id,
                                   logic [DELAY_W-1:0] ticks);
    logic [DELAY_W-1:0] owed;
    int                 last_grant;
    report_t            w;
    case (kind)
      K_CREATE: begin
        task_made[id] = 1'b1;
        task_st[id]   = TS_READY;
        task_dly[id]  = '0;
      end
      K_STOP:  task_st[id] = TS_STOP;
      K_READY: task_st[id] = TS_READY;
      K_SLEEP: begin
        task_dly[id] = ticks;
        task_st[id]  = TS_WAIT;
      end
      K_TICK: begin
        if (ticks_owed != '1) ticks_owed = ticks_owed + DELAY_W'(1);
      end
      K_SCHED: begin
        if (ticks_owed != '0) begin
          owed       = ticks_owed;
          ticks_owed = '0;
          last_grant = -1;
          for (int i = 0; i < TASKS; i++) begin
            if (task_made[i]) begin
              if (task_dly[i] <= owed) task_dly[i] = '0;
              else task_dly[i] = task_dly[i] - owed;
              if (task_dly[i] == '0 && task_st[i] == TS_WAIT) task_st[i] = TS_READY;
              if (task_st[i] == TS_READY) last_grant = i;
            end
          end
          if (last_grant < 0) begin
            // empty pass still reports once
            w = '{id: '0, granted: 1'b0, st: TS_READY, delay: '0, last: 1'b1};
            reports_due.push_back(w);
          end else begin
            for (int i = 0; i <= last_grant; i++) begin
              if (task_made[i] && task_st[i] == TS_READY) begin
                w = '{id: ID_W'(i), granted: 1'b1, st: TS_READY, delay: task_dly[i],
                      last: (i == last_grant)};
                reports_due.push_back(w);
              end
            end
          end
        end
      end
      K_QUERY: begin
        if (task_made[id]) begin
          w = '{id: id, granted: 1'b0, st: task_st[id], delay: task_dly[id], last: 1'b1};
        end else begin
          w = '{id: id, granted: 1'b0, st: TS_NONE, delay: '0, last: 1'b1};
        end
        reports_due.push_back(w);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [DELAY_W-1:0] want,
                             logic [DELAY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual tdata 0x%0h user %0d",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = reports_due.pop_front();
        check_field("task_id", DELAY_W'(want.id), DELAY_W'(out_tdata[3:0]));
        check_field("task_state", DELAY_W'(want.st), DELAY_W'(out_tdata[5:4]));
        check_field("delay", want.delay, out_tdata[37:6]);
        check_field("granted", DELAY_W'(want.granted), DELAY_W'(out_tuser[0]));
        check_field("last", DELAY_W'(want.last), DELAY_W'(out_tlast));
        reports_seen++;
        if (out_tuser[0]) grants_seen++;
      end
    end
  end

  // Called at a rising edge; leaves tvalid high so back-to-back words need no toggle.
  task automatic send_word(logic [2:0] kind, logic [ID_W-1:0] id,
                           logic [DELAY_W-1:0] ticks);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_DATA_W-ID_W-DELAY_W){1'b0}}, ticks, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    update_task_table(kind, id, ticks);
    words_sent++;
  endtask

  task automatic test_create_and_query();
    send_word(K_QUERY, 4'd0, '0);
    send_word(K_QUERY, 4'd15, '1);
    send_word(K_CREATE, 4'd0, '0);
    send_word(K_CREATE, 4'd15, '1);
    send_word(K_QUERY, 4'd0, '0);
    send_word(K_QUERY, 4'd15, '0);
  endtask

  task automatic test_grant_pass();
    send_word(K_SCHED, 4'd0, '0);  // no ticks owed: silent
    send_word(K_TICK, 4'd0, '0);
    send_word(K_TICK, 4'd0, '0);
    send_word(K_SCHED, 4'd0, '0);
  endtask

  task automatic test_sleep_wake();
    send_word(K_SLEEP, 4'd0, 32'd3);
    send_word(K_SLEEP, 4'd15, '1);
    send_word(K_TICK, 4'd0, '0);
    send_word(K_SCHED, 4'd0, '0);
    send_word(K_TICK, 4'd0, '0);
    send_word(K_TICK, 4'd0, '0);
    send_word(K_SCHED, 4'd0, '0);
  endtask

  task automatic test_stop_ready();
    send_word(K_STOP, 4'd0, '0);
    send_word(K_STOP, 4'd15, '0);
    send_word(K_TICK, 4'd0, '0);
    send_word(K_SCHED, 4'd0, '0);  // nothing ready: empty pass
    send_word(K_READY, 4'd15, '0);
    send_word(K_QUERY, 4'd15, '0);
  endtask

  task automatic test_ignored_words();
    send_word(K_UNUSED, 4'd15, '1);
    send_word(K_SLEEP, 4'd7, '0);  // task never created
    send_word(K_QUERY, 4'd7, '0);
    send_word(K_CREATE, 4'd7, 32'hA5A5_5A5A);
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall);
    int                 done;
    int                 pick;
    logic [2:0]         kind;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] ticks;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    done          = 0;
    while (done < count) begin
      pick  = $urandom_range(99);
      id    = ID_W'($urandom_range(TASKS - 1));
      ticks = $urandom;
      if (pick < 12) begin
        kind = K_CREATE;
      end else if (pick < 22) begin
        kind = K_SLEEP;
        case ($urandom_range(9))
          0: ticks = '1;
          1: ticks = $urandom;
          2: ticks = '0;
          default: ticks = $urandom_range(6);
        endcase
      end else if (pick < 28) begin
        kind = K_STOP;
      end else if (pick < 36) begin
        kind = K_READY;
      end else if (pick < 58) begin
        kind = K_TICK;
      end else if (pick < 72) begin
        kind = K_SCHED;
      end else if (pick < 90) begin
        kind = K_QUERY;
      end else begin
        kind = 3'($urandom_range(7));  // noise, unused kind included
      end
      send_word(kind, id, ticks);
      if (kind != K_UNUSED) done++;
    end
  endtask

  initial begin
    for (int i = 0; i < TASKS; i++) begin
      task_made[i] = 1'b0;
      task_st[i]   = TS_READY;
      task_dly[i]  = '0;
    end
    ticks_owed = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_create_and_query();
    test_grant_pass();
    test_sleep_wake();
    test_stop_ready();
    test_ignored_words();
    test_random_traffic(83, 0, 0);
    test_random_traffic(100, 64, 0);
    test_random_traffic(100, 0, 64);
    test_random_traffic(100, 25, 25);

    in_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d event words (create/stop/ready/sleep/tick/pass/query) under four",
             words_sent);
    $display("sender/receiver pacing mixes; checked %0d result words, %0d of them grants.",
             reports_seen, grants_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* tick_delay_task_scheduler_unit.f */
+incdir+hdl
hdl/tdts_pkg.sv
hdl/tdts_ram.sv
hdl/tdts_delay_unit.sv
hdl/tick_delay_task_scheduler_unit.sv
bench/tick_delay_task_scheduler_unit_test.sv
